// ===== rtl/dftw_pkg.sv =====
// ----------------------------------------------------------------------------
// Duplicate filter package
// Shared types, codes and defaults of the time-window duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dftw_pkg;

   // Default size of the table of recent hashes.
   localparam int ENTRIES_DEFAULT = 16;

   // Field widths.
   localparam int KIND_W  = 2;
   localparam int HASH_W  = 64;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 32;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_WINDOW = 3'd0;
   localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd60000;

   // Item kinds; the fourth code behaves as check only.
   localparam logic [KIND_W-1:0] KIND_CHECK_RECORD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHECK_ONLY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECORD_ONLY  = 2'd2;

   // Input word.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [HASH_W-1:0] item_hash;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   // Result word.
   typedef struct packed {
      logic               is_duplicate;
      logic [COUNT_W-1:0] duplicate_count;
   } rsp_type;

   // One stored table entry.
   typedef struct packed {
      logic [HASH_W-1:0] entry_hash;
      logic [TIME_W-1:0] entry_time;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/dftw_table.sv =====
// ----------------------------------------------------------------------------
// Duplicate filter table
// Hash and time memory with one write port and one registered read port,
// plus a used bit per entry in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dftw_table #(
   parameter int ENTRIES = dftw_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_idx,
   output logic                            rd_used,
   output dftw_pkg::entry_type             rd_entry,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_idx,
   input  wire dftw_pkg::entry_type        wr_entry
);
   import dftw_pkg::*;

   entry_type           entry_mem_ff [ENTRIES];
   logic [ENTRIES-1:0]  used_ff;
   logic [ENTRIES-1:0]  used_in;
   logic                rd_used_ff;
   entry_type           rd_entry_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= entry_mem_ff[rd_idx];
   end

   // Used bits: set on write, never cleared but by reset.
   always_comb begin
      used_in = used_ff;
      if (wr_en) begin
         used_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_used_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         rd_used_ff <= used_ff[rd_idx];
      end
   end

   assign rd_used  = rd_used_ff;
   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

// ===== rtl/dftw_match.sv =====
// ----------------------------------------------------------------------------
// Duplicate filter compare unit
// Shared unit that tests one table entry against the item: used, equal hash
// and an age, taken modulo 2^32, no greater than the window.
// ----------------------------------------------------------------------------
`default_nettype none

module dftw_match (
   input  wire logic                               entry_used,
   input  wire dftw_pkg::entry_type                entry,
   input  wire logic [dftw_pkg::HASH_W-1:0]        item_hash,
   input  wire logic [dftw_pkg::TIME_W-1:0]        now_ms,
   input  wire logic [dftw_pkg::TIME_W-1:0]        window_ms,
   output logic                                    match
);
   import dftw_pkg::*;

   logic [TIME_W-1:0] age;

   // The subtraction wraps naturally at the field width.
   assign age   = now_ms - entry.entry_time;
   assign match = entry_used && (entry.entry_hash == item_hash) && (age <= window_ms);

endmodule

`default_nettype wire

// ===== rtl/duplicate_filter_time_window.sv =====
// ----------------------------------------------------------------------------
// Time-window duplicate filter
// Sequencer, configuration register and result register of the filter.
// ----------------------------------------------------------------------------
// An item of kind check (with or without recording) is handled in a scan: the
// table is read one entry per cycle through a single registered read port and
// each entry passes the one compare unit, followed by a drain step to finish
// the last compare and a finish step to record and load the result. A
// record-only item goes straight to the finish step. The input
// stalls while an item is in progress; a finished result waits in its own
// register, so the next item can be taken before the result is collected.
// The table needs no clearing pass after reset.
`default_nettype none

module duplicate_filter_time_window #(
   parameter int ENTRIES = dftw_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire dftw_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output dftw_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [dftw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [dftw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dftw_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import dftw_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]          state_ff, state_in;
   req_type             item_ff, item_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    replace_ptr_ff, replace_ptr_in;
   logic [COUNT_W-1:0]  dup_count_ff, dup_count_in;
   logic [TIME_W-1:0]   window_ff, window_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_accept;
   logic                rsp_free;
   logic                csr_write;
   logic                rd_used;
   entry_type           rd_entry;
   logic                wr_en;
   entry_type           wr_entry;
   logic                match;
   logic                record;

   // Table of recent hashes.
   dftw_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (scan_idx_ff),
      .rd_used  (rd_used),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (replace_ptr_ff),
      .wr_entry (wr_entry)
   );

   // Shared compare unit.
   dftw_match u_match (
      .entry_used (rd_used),
      .entry      (rd_entry),
      .item_hash  (item_ff.item_hash),
      .now_ms     (item_ff.now_ms),
      .window_ms  (window_ff),
      .match      (match)
   );

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration port: one window register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_ADDR_WINDOW[CSR_ADDR_W-1])
                       ? window_ff : '0;

   always_comb begin
      window_in = window_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1] == CSR_ADDR_WINDOW[CSR_ADDR_W-1])) begin
         window_in = csr_pwdata;
      end
   end

   // Recording happens in the finish step: always for record only, and on a
   // miss for check and record.
   assign record = (item_ff.kind == KIND_RECORD_ONLY) ||
                   ((item_ff.kind == KIND_CHECK_RECORD) && !hit_ff);
   assign wr_en  = (state_ff == ST_FINISH) && rsp_free && record;
   assign wr_entry.entry_hash = item_ff.item_hash;
   assign wr_entry.entry_time = item_ff.now_ms;

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      scan_idx_in    = scan_idx_ff;
      rd_valid_in    = (state_ff == ST_SCAN);
      hit_in         = hit_ff || (rd_valid_ff && match);
      replace_ptr_in = replace_ptr_ff;
      dup_count_in   = dup_count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in     = req_data;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               if (req_data.kind == KIND_RECORD_ONLY) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.is_duplicate    = hit_ff;
               rsp_in.duplicate_count = dup_count_ff + COUNT_W'(hit_ff);
               dup_count_in           = dup_count_ff + COUNT_W'(hit_ff);
               if (record) begin
                  replace_ptr_in = (replace_ptr_ff == LAST_IDX) ? '0
                                   : replace_ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_valid_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         scan_idx_ff    <= '0;
         replace_ptr_ff <= '0;
         dup_count_ff   <= '0;
         window_ff      <= WINDOW_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_valid_ff    <= rd_valid_in;
         hit_ff         <= hit_in;
         scan_idx_ff    <= scan_idx_in;
         replace_ptr_ff <= replace_ptr_in;
         dup_count_ff   <= dup_count_in;
         window_ff      <= window_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
